@@ design/wpc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard pattern classifier package
// Shared widths, class codes, register indexes and types.
// ----------------------------------------------------------------------------
package wpc_pkg;

  localparam int MAX_LEN = 4096;
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int MARK_W  = 7;
  localparam int CLS_W   = 3;
  localparam int IDX_W   = 2;

  localparam logic [CLS_W-1:0] CLS_TERM           = 3'd0;
  localparam logic [CLS_W-1:0] CLS_TERM_ESCAPED   = 3'd1;
  localparam logic [CLS_W-1:0] CLS_PREFIX         = 3'd2;
  localparam logic [CLS_W-1:0] CLS_PREFIX_ESCAPED = 3'd3;
  localparam logic [CLS_W-1:0] CLS_MATCH_ALL      = 3'd4;
  localparam logic [CLS_W-1:0] CLS_WILDCARD       = 3'd5;
  localparam logic [CLS_W-1:0] CLS_INVALID        = 3'd6;
  localparam logic [CLS_W-1:0] CLS_TOO_LONG       = 3'd7;

  localparam logic [IDX_W-1:0] REG_ANY_STRING = 2'd0;
  localparam logic [IDX_W-1:0] REG_ANY_CHAR   = 2'd1;
  localparam logic [IDX_W-1:0] REG_ESCAPE     = 2'd2;

  localparam logic [MARK_W-1:0] ANY_STRING_RST = 7'd37;
  localparam logic [MARK_W-1:0] ANY_CHAR_RST   = 7'd95;
  localparam logic [MARK_W-1:0] ESCAPE_RST     = 7'd92;

  typedef struct packed {
    logic [7:0] pattern_byte;
    logic       has_byte;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [MARK_W-1:0] multi_mark;
    logic [MARK_W-1:0] single_mark;
    logic [MARK_W-1:0] escape;
  } marks_t;

endpackage
`default_nettype wire

@@ design/wpc_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard pattern classifier core
// Per-pattern state, combinational byte update and end-of-pattern class.
// ----------------------------------------------------------------------------
module wpc_core (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      step,
  input  wire wpc_pkg::item_t            item,
  input  wire wpc_pkg::marks_t           marks,
  output logic [wpc_pkg::CLS_W-1:0]      class_next
);

  typedef struct packed {
    logic                      escape_pending;
    logic                      escape_seen;
    logic [wpc_pkg::CNT_W-1:0] star_total;
    logic [wpc_pkg::CNT_W-1:0] star_tail_run;
    logic [wpc_pkg::CNT_W-1:0] bytes_seen;
    logic [1:0]                continuation_left;
    logic                      wildcard_fixed;
    logic                      invalid_fixed;
    logic                      length_overflow;
  } state_t;

  localparam logic [wpc_pkg::CNT_W-1:0] MAX_CNT = wpc_pkg::CNT_W'(wpc_pkg::MAX_LEN);
  localparam logic [wpc_pkg::CNT_W-1:0] CNT_ONE = wpc_pkg::CNT_W'(1);

  state_t st;
  state_t upd;
  state_t st_next;
  logic   lead_ok;
  logic [1:0] lead_extra;
  logic [7:0] b;

  assign b = item.pattern_byte;

  // Lead byte decode: number of continuation bytes owed
  always_comb begin
    lead_ok    = 1'b1;
    lead_extra = 2'd0;
    if (b[7] == 1'b0) begin
      lead_extra = 2'd0;
    end else if (b[7:6] == 2'b10) begin
      lead_ok = 1'b0;
    end else if (b[7:5] == 3'b110) begin
      lead_extra = 2'd1;
    end else if (b[7:4] == 4'b1110) begin
      lead_extra = 2'd2;
    end else if (b[7:3] == 5'b11110) begin
      lead_extra = 2'd3;
    end else begin
      lead_ok = 1'b0;
    end
  end

  always_comb begin
    upd = st;
    if (item.has_byte) begin
      if (st.bytes_seen >= MAX_CNT) begin
        upd.length_overflow = 1'b1;
      end else begin
        upd.bytes_seen = st.bytes_seen + CNT_ONE;
        if (st.continuation_left != 2'd0) begin
          upd.continuation_left = st.continuation_left - 2'd1;
        end else if (!(st.wildcard_fixed || st.invalid_fixed)) begin
          if (!lead_ok) begin
            upd.invalid_fixed = 1'b1;
          end else begin
            upd.continuation_left = lead_extra;
            if (b == {1'b0, marks.multi_mark}) begin
              if (!st.escape_pending) begin
                upd.star_tail_run = st.star_tail_run + CNT_ONE;
                upd.star_total    = st.star_total + CNT_ONE;
              end
              upd.escape_seen    = st.escape_seen || st.escape_pending;
              upd.escape_pending = 1'b0;
            end else if (b == {1'b0, marks.single_mark}) begin
              if (!st.escape_pending) begin
                upd.wildcard_fixed = 1'b1;
              end else begin
                upd.escape_seen    = 1'b1;
                upd.star_tail_run  = '0;
                upd.escape_pending = 1'b0;
              end
            end else if (b == {1'b0, marks.escape}) begin
              upd.star_tail_run  = '0;
              upd.escape_seen    = st.escape_seen || st.escape_pending;
              upd.escape_pending = !st.escape_pending;
            end else begin
              upd.star_tail_run  = '0;
              upd.escape_pending = 1'b0;
            end
          end
        end
      end
    end
  end

  always_comb begin
    if (upd.length_overflow) begin
      class_next = wpc_pkg::CLS_TOO_LONG;
    end else if (upd.wildcard_fixed) begin
      class_next = wpc_pkg::CLS_WILDCARD;
    end else if (upd.invalid_fixed || upd.continuation_left != 2'd0) begin
      class_next = wpc_pkg::CLS_INVALID;
    end else if (upd.bytes_seen == '0) begin
      class_next = wpc_pkg::CLS_TERM;
    end else if (upd.star_total == '0) begin
      class_next = upd.escape_seen ? wpc_pkg::CLS_TERM_ESCAPED : wpc_pkg::CLS_TERM;
    end else if (upd.star_total == upd.bytes_seen) begin
      class_next = wpc_pkg::CLS_MATCH_ALL;
    end else if (upd.star_total == upd.star_tail_run) begin
      class_next = upd.escape_seen ? wpc_pkg::CLS_PREFIX_ESCAPED : wpc_pkg::CLS_PREFIX;
    end else begin
      class_next = wpc_pkg::CLS_WILDCARD;
    end
  end

  // Clear after the last byte of a pattern
  always_comb begin
    st_next = st;
    if (step) begin
      st_next = item.last ? '0 : upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else begin
      st <= st_next;
    end
  end

endmodule
`default_nettype wire

@@ design/wildcard_pattern_classifier_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard pattern classifier unit
// Streams a UTF-8 wildcard pattern in byte by byte and returns its class.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream s_*: one pattern byte per transaction, tuser = has_byte,
//   tlast marks the final byte. A transaction with tuser low and tlast high
//   ends the pattern without a byte (an empty pattern if nothing came before).
//   Master stream m_*: one transaction per pattern, carrying the class code.
//   Configuration: cfg_we writes cfg_data into the mark register at cfg_index
//   (0 any-string, 1 any-char, 2 escape); write only while idle.
// Timing:
//   Each byte is registered on entry, then taken by the combinational state
//   update; one byte is taken every cycle unless a final byte is stalled.
//   Taking the last byte registers the class and raises m_tvalid.
//   A stalled receiver holds the result; non-final bytes keep flowing, and a
//   final byte waits in the input register until the result slot frees.
// Reset:
//   rst clears the pattern state and both stages and restores the marks
//   to their defaults (37, 95, 92).
// ----------------------------------------------------------------------------
module wildcard_pattern_classifier_unit (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        s_tvalid,
  output logic                             s_tready,
  input  wire logic [7:0]                  s_tdata,  // [7:0] pattern_byte
  input  wire logic                        s_tuser,  // [0] has_byte
  input  wire logic                        s_tlast,
  output logic                             m_tvalid,
  input  wire logic                        m_tready,
  output logic [7:0]                       m_tdata,  // [2:0] pattern_class
  input  wire logic                        cfg_we,
  input  wire logic [wpc_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [wpc_pkg::MARK_W-1:0]  cfg_data
);

  wpc_pkg::marks_t marks;
  wpc_pkg::item_t  item;
  logic            item_valid;
  logic            step;
  logic [wpc_pkg::CLS_W-1:0] class_next;
  logic [wpc_pkg::CLS_W-1:0] result;

  always_ff @(posedge clk) begin
    if (rst) begin
      marks.multi_mark  <= wpc_pkg::ANY_STRING_RST;
      marks.single_mark <= wpc_pkg::ANY_CHAR_RST;
      marks.escape      <= wpc_pkg::ESCAPE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        wpc_pkg::REG_ANY_STRING: marks.multi_mark  <= cfg_data;
        wpc_pkg::REG_ANY_CHAR:   marks.single_mark <= cfg_data;
        wpc_pkg::REG_ESCAPE:     marks.escape      <= cfg_data;
        default: ;
      endcase
    end
  end

  assign step     = item_valid && (!item.last || !m_tvalid || m_tready);
  assign s_tready = !item_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item.pattern_byte <= s_tdata;
      item.has_byte     <= s_tuser;
      item.last         <= s_tlast;
    end
  end

  wpc_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .item       (item),
    .marks      (marks),
    .class_next (class_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      m_tvalid <= (step && item.last) || (m_tvalid && !m_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (step && item.last) begin
      result <= class_next;
    end
  end

  assign m_tdata = {{(8 - wpc_pkg::CLS_W){1'b0}}, result};

endmodule
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Wildcard pattern classifier testbench
// Streams UTF-8 wildcard patterns through the unit under several mark
// settings, predicts the class of each pattern and checks every class
// returned, with random idle bursts on both streams.
// ----------------------------------------------------------------------------
module tb;
  import wpc_pkg::*;

  localparam int CYCLE_LIMIT = 5_000_000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata = '0;
  logic              s_tuser = 1'b0;
  logic              s_tlast = 1'b0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;
  logic              cfg_we = 1'b0;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [MARK_W-1:0] cfg_data = '0;

  marks_t           marks = '{ANY_STRING_RST, ANY_CHAR_RST, ESCAPE_RST};
  item_t            pending[$];
  item_t            on_bus;
  logic [CLS_W-1:0] class_due[$];
  logic [CLS_W-1:0] due;
  bit               idle_on = 1'b1;
  int               src_gap = 0;
  int               sink_gap = 0;
  int               queued_items = 0;
  int               faults = 0;
  int               cycles = 0;

  // pattern state of the predictor
  logic             esc_armed, esc_used, wild_lock, bad_lock, over_len;
  logic [CNT_W-1:0] star_cnt, star_tail, byte_cnt;
  logic [1:0]       cont_owed;

  wildcard_pattern_classifier_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [2:0] lead_len(logic [7:0] b);
    if (b < 8'h80) return 3'd1;
    if (b < 8'hC0) return 3'd0;
    if (b < 8'hE0) return 3'd2;
    if (b < 8'hF0) return 3'd3;
    if (b < 8'hF8) return 3'd4;
    return 3'd0;
  endfunction

  task automatic clear_pattern();
    esc_armed = 1'b0;
    esc_used  = 1'b0;
    wild_lock = 1'b0;
    bad_lock  = 1'b0;
    over_len  = 1'b0;
    star_cnt  = '0;
    star_tail = '0;
    byte_cnt  = '0;
    cont_owed = '0;
  endtask

  task automatic absorb_byte(logic [7:0] b);
    logic [2:0] n;
    n = lead_len(b);
    if (byte_cnt >= MAX_LEN) begin
      over_len = 1'b1;
      return;
    end
    byte_cnt++;
    if (cont_owed != 0) begin
      cont_owed--;
      return;
    end
    if (wild_lock || bad_lock) return;
    if (n == 0) begin
      bad_lock = 1'b1;
      return;
    end
    cont_owed = 2'(n - 3'd1);
    if (b == {1'b0, marks.multi_mark}) begin
      if (!esc_armed) begin
        star_tail++;
        star_cnt++;
      end
      esc_used  = esc_used | esc_armed;
      esc_armed = 1'b0;
    end else if (b == {1'b0, marks.single_mark}) begin
      if (!esc_armed) begin
        wild_lock = 1'b1;
        return;
      end
      esc_used  = 1'b1;
      star_tail = '0;
      esc_armed = 1'b0;
    end else if (b == {1'b0, marks.escape}) begin
      star_tail = '0;
      esc_used  = esc_used | esc_armed;
      esc_armed = !esc_armed;
    end else begin
      star_tail = '0;
      esc_armed = 1'b0;
    end
  endtask

  function automatic logic [CLS_W-1:0] class_now();
    if (over_len) return CLS_TOO_LONG;
    if (wild_lock) return CLS_WILDCARD;
    if (bad_lock || cont_owed != 0) return CLS_INVALID;
    if (byte_cnt == 0) return CLS_TERM;
    if (star_cnt == 0) return esc_used ? CLS_TERM_ESCAPED : CLS_TERM;
    if (star_cnt == byte_cnt) return CLS_MATCH_ALL;
    if (star_cnt == star_tail) return esc_used ? CLS_PREFIX_ESCAPED : CLS_PREFIX;
    return CLS_WILDCARD;
  endfunction

  // byte driver and predictor update on each accepted transaction
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
      clear_pattern();
    end else begin
      if (s_tvalid && s_tready) begin
        if (on_bus.has_byte) absorb_byte(on_bus.pattern_byte);
        if (on_bus.last) begin
          class_due.push_back(class_now());
          clear_pattern();
        end
      end
      if (!s_tvalid || s_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_tvalid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
          src_gap = $urandom_range(0, 13);
          s_tvalid <= 1'b0;
        end else if (pending.size() > 0) begin
          on_bus = pending.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= on_bus.pattern_byte;
          s_tuser  <= on_bus.has_byte;
          s_tlast  <= on_bus.last;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // class monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (class_due.size() == 0) begin
          if (faults < 10) $display("class %0d returned with none due", m_tdata[CLS_W-1:0]);
          faults++;
        end else begin
          due = class_due.pop_front();
          if (m_tdata[CLS_W-1:0] !== due) begin
            if (faults < 10)
              $display("class mismatch: expected %0d, got %0d", due, m_tdata[CLS_W-1:0]);
            faults++;
          end
        end
      end
      if (sink_gap > 0) begin
        sink_gap--;
        m_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        sink_gap = $urandom_range(0, 13);
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic push_item(logic [7:0] b, logic has, logic fin);
    item_t it;
    it.pattern_byte = b;
    it.has_byte     = has;
    it.last         = fin;
    pending.push_back(it);
    if (has || fin) queued_items++;
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b1, i == s.len() - 1);
  endtask

  task automatic queue_run(int n, logic [7:0] b, bit end_bare);
    for (int i = 0; i < n; i++) push_item(b, 1'b1, !end_bare && i == n - 1);
    if (end_bare) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic queue_random_pattern();
    logic [7:0] bytes[$];
    int         shape, n, r, k, p_star, p_char;
    bit         end_bare;
    shape    = $urandom_range(0, 99);
    end_bare = ($urandom_range(0, 6) == 0);
    if (shape < 3) begin
      push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      return;
    end
    if (shape < 10) begin
      n = $urandom_range(1, 8);
      repeat (n) bytes.push_back(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 3))
        0:       p_star = 0;
        1:       p_star = 10;
        2:       p_star = 30;
        default: p_star = 70;
      endcase
      p_char = ($urandom_range(0, 3) == 0) ? 5 : 0;
      n = $urandom_range(1, 16);
      while (bytes.size() < n) begin
        r = $urandom_range(0, 99);
        if (r < p_star) begin
          bytes.push_back({1'b0, marks.multi_mark});
        end else if (r < p_star + p_char) begin
          bytes.push_back({1'b0, marks.single_mark});
        end else if (r < p_star + p_char + 8) begin
          bytes.push_back({1'b0, marks.escape});
        end else if (r < p_star + p_char + 14) begin
          k = $urandom_range(2, 4);
          case (k)
            2:       bytes.push_back(8'hC0 | 8'($urandom_range(0, 31)));
            3:       bytes.push_back(8'hE0 | 8'($urandom_range(0, 15)));
            default: bytes.push_back(8'hF0 | 8'($urandom_range(0, 7)));
          endcase
          repeat (k - 1) bytes.push_back(8'($urandom_range(0, 255)));
        end else if (r < p_star + p_char + 16) begin
          bytes.push_back($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                              : 8'($urandom_range(8'hF8, 8'hFF)));
        end else begin
          bytes.push_back(8'($urandom_range(0, 127)));
        end
      end
      if ($urandom_range(0, 3) == 0)
        repeat ($urandom_range(1, 3)) bytes.push_back({1'b0, marks.multi_mark});
      if ($urandom_range(0, 19) == 0) bytes.push_back(8'($urandom_range(8'hC0, 8'hF7)));
    end
    foreach (bytes[i]) begin
      if ($urandom_range(0, 32) == 0) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      push_item(bytes[i], 1'b1, !end_bare && i == bytes.size() - 1);
    end
    if (end_bare) push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic fill_random(int n);
    int start;
    start = queued_items;
    while (queued_items - start < n) queue_random_pattern();
  endtask

  task automatic write_marks(logic [MARK_W-1:0] str, logic [MARK_W-1:0] chr,
                             logic [MARK_W-1:0] esc);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_ANY_STRING;
    cfg_data  <= str;
    @(posedge clk);
    cfg_index <= REG_ANY_CHAR;
    cfg_data  <= chr;
    @(posedge clk);
    cfg_index <= REG_ESCAPE;
    cfg_data  <= esc;
    @(posedge clk);
    cfg_we    <= 1'b0;
    marks = '{str, chr, esc};
  endtask

  // hold until every transaction has gone through and every class returned
  task automatic settle();
    while (pending.size() != 0 || s_tvalid || class_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    push_item(8'h5A, 1'b0, 1'b1);
    queue_text("a");
    queue_text("%");
    queue_text("ab%");
    queue_text("\\_x%");
    queue_text("a\\%");
    queue_text("_");
    push_item(8'h80, 1'b1, 1'b1);
    push_item(8'hC3, 1'b1, 1'b1);
    push_item(8'hE2, 1'b1, 1'b0);
    push_item(8'h82, 1'b1, 1'b0);
    push_item(8'hAC, 1'b1, 1'b1);
    queue_text("\\");
    push_item(8'hA5, 1'b0, 1'b0);
    push_item("x", 1'b1, 1'b0);
    push_item(8'h00, 1'b0, 1'b1);
    push_item(8'h90, 1'b1, 1'b0);
    push_item("_", 1'b1, 1'b1);
    push_item("_", 1'b1, 1'b0);
    push_item(8'h90, 1'b1, 1'b1);
    settle();

    fill_random(300);
    settle();

    queue_run(MAX_LEN, {1'b0, marks.multi_mark}, 1'b0);
    queue_run(MAX_LEN + 1, "a", 1'b0);
    queue_run(MAX_LEN + 2, {1'b0, marks.escape}, 1'b1);
    settle();

    write_marks('0, '0, '0);
    fill_random(200);
    settle();

    write_marks('1, '1, '1);
    idle_on = 1'b0;
    fill_random(200);
    settle();

    idle_on = 1'b1;
    write_marks(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                7'($urandom_range(0, 127)));
    fill_random(300);
    settle();

    write_marks(7'($urandom_range(0, 127)), marks.single_mark, marks.single_mark);
    fill_random(300);
    settle();

    write_marks(ANY_STRING_RST, ANY_CHAR_RST, ESCAPE_RST);
    idle_on = 1'b0;
    fill_random(200);
    settle();

    if (faults == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
